@@ rtl/gesture_confirm_arbiter_top_defines.svh @@
// Assertion macros used by the gesture confirm arbiter checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef GESTURE_CONFIRM_ARBITER_TOP_DEFINES_SVH
`define GESTURE_CONFIRM_ARBITER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define GCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gca check failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define GCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gca check failed: next-cycle implication");

`endif

@@ rtl/gca_pkg.sv @@
// Shared constants for the gesture confirm arbiter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package gca_pkg;

  localparam int ID_BITS_DEFAULT     = 8;
  localparam int SOURCE_BITS_DEFAULT = 2;

  localparam int TIME_BITS      = 32;
  localparam int CONF_BITS      = 16;
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_COOLDOWN = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONFIRM  = 8'd1;

  localparam logic [CFG_BITS-1:0] COOLDOWN_RESET = 16'd1000;
  localparam logic [CFG_BITS-1:0] CONFIRM_RESET  = 16'd300;

endpackage

@@ rtl/gca_lane.sv @@
// One candidate lane: checks a gesture candidate for validity.
// Depends on gca_pkg for the confidence width.
`timescale 1ns / 1ps

module gca_lane #(
  parameter int ID_BITS     = gca_pkg::ID_BITS_DEFAULT,
  parameter int SOURCE_BITS = gca_pkg::SOURCE_BITS_DEFAULT
) (
  input  logic [SOURCE_BITS-1:0]              source,
  input  logic [ID_BITS-1:0]                  gesture_id,
  input  logic signed [gca_pkg::CONF_BITS-1:0] confidence,
  output logic                                ok
);

  // Valid: known source, nonempty id, sign bit clear
  assign ok = (source != '0) && (gesture_id != '0) &&
              !confidence[gca_pkg::CONF_BITS-1];

endmodule

@@ rtl/gca_core.sv @@
// Merge of the two lanes, pending-gesture state, cooldown and result register.
// Depends on gca_pkg; fed by two gca_lane instances.
`timescale 1ns / 1ps

module gca_core #(
  parameter int ID_BITS     = gca_pkg::ID_BITS_DEFAULT,
  parameter int SOURCE_BITS = gca_pkg::SOURCE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [gca_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [gca_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 step,
  input  logic                                 take,
  input  logic [gca_pkg::TIME_BITS-1:0]        now_ms,
  input  logic                                 single_ok,
  input  logic [SOURCE_BITS-1:0]               single_source,
  input  logic [ID_BITS-1:0]                   single_gesture_id,
  input  logic signed [gca_pkg::CONF_BITS-1:0] single_confidence,
  input  logic                                 bimanual_ok,
  input  logic [SOURCE_BITS-1:0]               bimanual_source,
  input  logic [ID_BITS-1:0]                   bimanual_gesture_id,
  input  logic signed [gca_pkg::CONF_BITS-1:0] bimanual_confidence,
  output logic                                 out_valid,
  output logic                                 announce,
  output logic [SOURCE_BITS-1:0]               out_source,
  output logic [ID_BITS-1:0]                   out_gesture_id,
  output logic signed [gca_pkg::CONF_BITS-1:0] out_confidence,
  output logic [gca_pkg::CFG_BITS-1:0]         cooldown_left
);

  localparam int TB = gca_pkg::TIME_BITS;
  localparam int CB = gca_pkg::CONF_BITS;
  localparam int RB = gca_pkg::CFG_BITS;

  logic [RB-1:0]          cooldown_ms;
  logic [RB-1:0]          confirm_ms;

  logic [ID_BITS-1:0]     pend_id, pend_id_next;
  logic [SOURCE_BITS-1:0] pend_source, pend_source_next;
  logic [CB-1:0]          pend_conf, pend_conf_next;
  logic [TB-1:0]          pend_start, pend_start_next;
  logic [ID_BITS-1:0]     last_said_id, last_said_id_next;
  logic [TB-1:0]          last_said_time, last_said_time_next;
  logic                   after_cool_cleared, after_cool_cleared_next;

  logic                   have;
  logic [ID_BITS-1:0]     w_id;
  logic [SOURCE_BITS-1:0] w_src;
  logic [CB-1:0]          w_conf;
  logic                   said_set;
  logic [TB-1:0]          el_cool;
  logic                   in_cool;
  logic [ID_BITS-1:0]     id0;
  logic [TB-1:0]          start0;
  logic [TB-1:0]          el_conf;
  logic                   ann;
  logic [RB-1:0]          rem;

  // Merge lanes: two-hand candidate wins
  assign have   = bimanual_ok || single_ok;
  assign w_id   = bimanual_ok ? bimanual_gesture_id : single_gesture_id;
  assign w_src  = bimanual_ok ? bimanual_source     : single_source;
  assign w_conf = bimanual_ok ? bimanual_confidence : single_confidence;

  // Cooldown window, wrapping time difference
  assign said_set = (last_said_time != '0);
  assign el_cool  = now_ms - last_said_time;
  assign in_cool  = said_set && (el_cool < {{(TB-RB){1'b0}}, cooldown_ms});

  // Next state of the pending gesture and announcement
  always_comb begin
    pend_id_next            = pend_id;
    pend_source_next        = pend_source;
    pend_conf_next          = pend_conf;
    pend_start_next         = pend_start;
    last_said_id_next       = last_said_id;
    last_said_time_next     = last_said_time;
    after_cool_cleared_next = after_cool_cleared;
    id0                     = pend_id;
    start0                  = pend_start;
    el_conf                 = '0;
    ann                     = 1'b0;
    if (in_cool) begin
      if (have) begin
        pend_id_next     = w_id;
        pend_source_next = w_src;
        pend_conf_next   = w_conf;
      end
      after_cool_cleared_next = 1'b0;
    end else begin
      // drop the pending gesture once, on the first tick past the cooldown
      if (said_set && !after_cool_cleared) begin
        id0                     = '0;
        start0                  = '0;
        after_cool_cleared_next = 1'b1;
      end
      if (have) begin
        pend_start_next  = (w_id != id0) ? now_ms : start0;
        pend_id_next     = w_id;
        pend_source_next = w_src;
        pend_conf_next   = w_conf;
      end else begin
        pend_id_next     = '0;
        pend_source_next = '0;
        pend_conf_next   = '0;
        pend_start_next  = '0;
      end
      el_conf = now_ms - pend_start_next;
      if ((pend_id_next != '0) &&
          (el_conf >= {{(TB-RB){1'b0}}, confirm_ms}) &&
          (pend_id_next != last_said_id)) begin
        ann                 = 1'b1;
        last_said_id_next   = pend_id_next;
        last_said_time_next = now_ms;
      end
    end
  end

  // Cooldown left after this tick
  always_comb begin
    if (ann) begin
      rem = (now_ms != '0) ? cooldown_ms : '0;
    end else if (in_cool) begin
      rem = cooldown_ms - el_cool[RB-1:0];
    end else begin
      rem = '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_ms <= gca_pkg::COOLDOWN_RESET;
      confirm_ms  <= gca_pkg::CONFIRM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gca_pkg::REG_COOLDOWN: cooldown_ms <= cfg_data;
        gca_pkg::REG_CONFIRM:  confirm_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_id            <= '0;
      pend_source        <= '0;
      pend_conf          <= '0;
      pend_start         <= '0;
      last_said_id       <= '0;
      last_said_time     <= '0;
      after_cool_cleared <= 1'b0;
    end else if (step) begin
      if (ann) begin
        pend_id     <= '0;
        pend_source <= '0;
        pend_conf   <= '0;
        pend_start  <= '0;
      end else begin
        pend_id     <= pend_id_next;
        pend_source <= pend_source_next;
        pend_conf   <= pend_conf_next;
        pend_start  <= pend_start_next;
      end
      last_said_id       <= last_said_id_next;
      last_said_time     <= last_said_time_next;
      after_cool_cleared <= after_cool_cleared_next;
    end
  end

  // Result register: hold while stalled, load on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      announce       <= ann;
      out_source     <= ann ? pend_source_next : '0;
      out_gesture_id <= ann ? pend_id_next : '0;
      out_confidence <= ann ? signed'(pend_conf_next) : '0;
      cooldown_left  <= rem;
    end
  end

endmodule

@@ rtl/gesture_confirm_arbiter_top.sv @@
// Gesture confirm arbiter: usage.
// Input channel (in_valid / in_stall) carries one tick: now_ms and two gesture
// candidates, single-hand and two-hand. Each lane checks its candidate; the
// core picks the two-hand one when both are valid.
// Output channel (out_valid / out_stall) carries exactly one result per tick:
// announce, the announced gesture (zeros when not announcing) and cooldown_left.
// The result is registered and appears in the cycle after its tick is taken;
// throughput is one tick per cycle while the receiver does not stall, set by the
// update of the pending-gesture and cooldown registers in front of the result register.
// When the receiver stalls, the result register holds its beat and in_stall
// rises; a new tick is taken in the same cycle the held result is taken.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready:
// index 0 is cooldown_ms, index 1 is confirm_ms, other indexes are ignored.
// Write it only while the block is idle.
// rst (synchronous, active high) clears the pending gesture and announcement
// history, empties the result register and sets cooldown_ms 1000, confirm_ms 300.
// Depends on gca_pkg, gca_lane and gca_core.
`timescale 1ns / 1ps

module gesture_confirm_arbiter_top #(
  parameter int ID_BITS     = gca_pkg::ID_BITS_DEFAULT,
  parameter int SOURCE_BITS = gca_pkg::SOURCE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gca_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [gca_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [gca_pkg::TIME_BITS-1:0]        now_ms,
  input  logic [SOURCE_BITS-1:0]               single_source,
  input  logic [ID_BITS-1:0]                   single_gesture_id,
  input  logic signed [gca_pkg::CONF_BITS-1:0] single_confidence,
  input  logic [SOURCE_BITS-1:0]               bimanual_source,
  input  logic [ID_BITS-1:0]                   bimanual_gesture_id,
  input  logic signed [gca_pkg::CONF_BITS-1:0] bimanual_confidence,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 announce,
  output logic [SOURCE_BITS-1:0]               out_source,
  output logic [ID_BITS-1:0]                   out_gesture_id,
  output logic signed [gca_pkg::CONF_BITS-1:0] out_confidence,
  output logic [gca_pkg::CFG_BITS-1:0]         cooldown_left
);

  logic single_ok;
  logic bimanual_ok;
  logic step;
  logic take;

  // Handshake: stall only while a result waits and the receiver stalls
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign step      = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;

  gca_lane #(.ID_BITS(ID_BITS), .SOURCE_BITS(SOURCE_BITS)) u_lane_single (
    .source     (single_source),
    .gesture_id (single_gesture_id),
    .confidence (single_confidence),
    .ok         (single_ok)
  );

  gca_lane #(.ID_BITS(ID_BITS), .SOURCE_BITS(SOURCE_BITS)) u_lane_bimanual (
    .source     (bimanual_source),
    .gesture_id (bimanual_gesture_id),
    .confidence (bimanual_confidence),
    .ok         (bimanual_ok)
  );

  gca_core #(.ID_BITS(ID_BITS), .SOURCE_BITS(SOURCE_BITS)) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .step                (step),
    .take                (take),
    .now_ms              (now_ms),
    .single_ok           (single_ok),
    .single_source       (single_source),
    .single_gesture_id   (single_gesture_id),
    .single_confidence   (single_confidence),
    .bimanual_ok         (bimanual_ok),
    .bimanual_source     (bimanual_source),
    .bimanual_gesture_id (bimanual_gesture_id),
    .bimanual_confidence (bimanual_confidence),
    .out_valid           (out_valid),
    .announce            (announce),
    .out_source          (out_source),
    .out_gesture_id      (out_gesture_id),
    .out_confidence      (out_confidence),
    .cooldown_left       (cooldown_left)
  );

endmodule

@@ rtl/gca_checker.sv @@
// Port-level checks for the gesture confirm arbiter, bound to the top level.
// Depends on gca_pkg and gesture_confirm_arbiter_top_defines.svh.
`timescale 1ns / 1ps
`include "gesture_confirm_arbiter_top_defines.svh"

module gca_checker #(
  parameter int ID_BITS     = gca_pkg::ID_BITS_DEFAULT,
  parameter int SOURCE_BITS = gca_pkg::SOURCE_BITS_DEFAULT
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 announce,
  input logic [SOURCE_BITS-1:0]               out_source,
  input logic [ID_BITS-1:0]                   out_gesture_id,
  input logic signed [gca_pkg::CONF_BITS-1:0] out_confidence
);

  // A held result beat keeps valid up
  `GCA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

  // An accepted tick yields a result beat in the next cycle
  `GCA_ASSERT_NXT(a_in_to_out, in_valid && !in_stall, out_valid)

  // A result waiting on a stalled receiver blocks the input
  `GCA_ASSERT_IMP(a_stall_back, out_valid && out_stall, in_stall)

  // A quiet result carries no gesture
  `GCA_ASSERT_IMP(a_quiet_zero, out_valid && !announce,
    out_gesture_id == '0 && out_source == '0 && out_confidence == '0)

  // An announced gesture is always a valid candidate
  `GCA_ASSERT_IMP(a_ann_valid, out_valid && announce,
    out_gesture_id != '0 && out_source != '0 &&
    !out_confidence[gca_pkg::CONF_BITS-1])

endmodule

bind gesture_confirm_arbiter_top gca_checker #(
  .ID_BITS(ID_BITS),
  .SOURCE_BITS(SOURCE_BITS)
) u_gca_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .announce       (announce),
  .out_source     (out_source),
  .out_gesture_id (out_gesture_id),
  .out_confidence (out_confidence)
);
